>>> hw/rtl/argb_box_downsampler_core_macros.svh
// ----------------------------------------------------------------------------
// argb_box_downsampler_core_macros.svh
// Assertion macros used by the box downsampler checker.
// ----------------------------------------------------------------------------
`ifndef ARGB_BOX_DOWNSAMPLER_CORE_MACROS_SVH
`define ARGB_BOX_DOWNSAMPLER_CORE_MACROS_SVH

// property checked outside reset
`define ABD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked during reset as well
`define ABD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// Widths, types and the reciprocal table of the ARGB box downsampler.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int MAX_OUT_WIDTH  = 2048;
  localparam int MAX_OUT_HEIGHT = 2048;
  localparam int MAX_SCALE      = 8;

  localparam int PIX_W   = 32;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 4;
  localparam int SCALE_W = 4;
  localparam int DIM_W   = 12;
  localparam int COL_W   = $clog2(MAX_OUT_WIDTH);
  localparam int ROW_W   = $clog2(MAX_OUT_HEIGHT);
  localparam int SUB_W   = $clog2(MAX_SCALE);
  // a block holds at most MAX_SCALE^2 pixels of 8 bits
  localparam int SUM_W   = CH_W + 2 * SUB_W;
  localparam int ENTRY_W = NUM_CH * SUM_W;

  // mean = (sum * ceil(2^RECIP_K / N^2)) >> RECIP_K, exact for SUM_W-bit sums
  localparam int RECIP_K = 20;
  localparam int RECIP_W = 19;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - RECIP_K;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] abd_sums_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } abd_cfg_t;

  typedef struct packed {
    logic capture;  // latch pixel, start sum read
    logic step;     // update sums, advance counters
    logic mul;      // reciprocal multiply
    logic load;     // fill output register
  } abd_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } abd_status_t;

  function automatic logic [RECIP_W-1:0] abd_recip(input logic [SCALE_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 19'd262144;
      4'd3:    r = 19'd116509;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd41944;
      4'd6:    r = 19'd29128;
      4'd7:    r = 19'd21400;
      4'd8:    r = 19'd16384;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/argb_box_downsampler_core.sv
// ----------------------------------------------------------------------------
// argb_box_downsampler_core
// Integer-factor box downscaler for a raster ARGB8888 pixel stream.
// ----------------------------------------------------------------------------
// Each source pixel is captured, then its column sum entry is updated by a
// read-modify-write of the column sum RAM (read on capture, write on step).
// A pixel that completes an N x N block then passes through the registered
// reciprocal multiply that forms the block mean, and its result waits behind
// any untaken result beat; no new pixel is taken until it is loaded. Column
// sums need no clearing after reset: the first pixel of each block loads its
// column entry. Registers: scale_factor at 0x0, output_width at 0x4,
// output_height at 0x8; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module argb_box_downsampler_core
  import abd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              src_valid,
  output logic              src_ready,
  input  logic [PIX_W-1:0]  source_pixel,
  output logic              dst_valid,
  input  logic              dst_ready,
  output logic [PIX_W-1:0]  averaged_pixel,
  output logic              line_end,
  output logic              frame_end
);

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  logic [SCALE_W-1:0] scale_factor;
  logic [DIM_W-1:0]   output_width;
  logic [DIM_W-1:0]   output_height;

  abd_cfg_t    cfg;
  abd_cmd_t    cmd;
  abd_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_W'(2);
      output_width  <= DIM_W'(1280);
      output_height <= DIM_W'(720);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SCALE:  scale_factor  <= pwdata[SCALE_W-1:0];
        REG_WIDTH:  output_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: output_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCALE:  prdata = 32'(scale_factor);
      REG_WIDTH:  prdata = 32'(output_width);
      REG_HEIGHT: prdata = 32'(output_height);
      default:    prdata = '0;
    endcase
  end

  // out-of-range settings act as the nearest legal value
  always_comb begin
    if (scale_factor < SCALE_W'(2)) begin
      cfg.scale = SCALE_W'(2);
    end else if (scale_factor > SCALE_W'(MAX_SCALE)) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale_factor;
    end
    if (output_width == '0) begin
      cfg.width = DIM_W'(1);
    end else if (output_width > DIM_W'(MAX_OUT_WIDTH)) begin
      cfg.width = DIM_W'(MAX_OUT_WIDTH);
    end else begin
      cfg.width = output_width;
    end
    if (output_height == '0) begin
      cfg.height = DIM_W'(1);
    end else if (output_height > DIM_W'(MAX_OUT_HEIGHT)) begin
      cfg.height = DIM_W'(MAX_OUT_HEIGHT);
    end else begin
      cfg.height = output_height;
    end
  end

  abd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .status    (status),
    .cmd       (cmd)
  );

  abd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .source_pixel   (source_pixel),
    .status         (status),
    .dst_ready      (dst_ready),
    .dst_valid      (dst_valid),
    .averaged_pixel (averaged_pixel),
    .line_end       (line_end),
    .frame_end      (frame_end)
  );

endmodule

>>> hw/rtl/abd_ram.sv
// ----------------------------------------------------------------------------
// abd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/abd_datapath.sv
// ----------------------------------------------------------------------------
// abd_datapath
// Raster counters, column sum RAM, reciprocal divide and output register.
// ----------------------------------------------------------------------------
module abd_datapath
  import abd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  abd_cmd_t          cmd,
  input  abd_cfg_t          cfg,
  input  logic [PIX_W-1:0]  source_pixel,
  output abd_status_t       status,
  input  logic              dst_ready,
  output logic              dst_valid,
  output logic [PIX_W-1:0]  averaged_pixel,
  output logic              line_end,
  output logic              frame_end
);

  logic [SUB_W-1:0] sub_col;
  logic [SUB_W-1:0] sub_row;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  logic [PIX_W-1:0] pixel;
  abd_sums_t        sums;
  abd_sums_t        sums_next;
  logic [ENTRY_W-1:0] rd_data;
  logic [PROD_W-1:0]  prod [NUM_CH];
  logic               line_flag;
  logic               frame_flag;
  logic [PIX_W-1:0]   mean_pixel;

  logic last_sub_col, last_sub_row, last_col, last_row, block_start;

  assign last_sub_col = (SCALE_W'(sub_col) + 1'b1) >= cfg.scale;
  assign last_sub_row = (SCALE_W'(sub_row) + 1'b1) >= cfg.scale;
  assign last_col     = (DIM_W'(out_col) + 1'b1) >= cfg.width;
  assign last_row     = (DIM_W'(out_row) + 1'b1) >= cfg.height;
  assign block_start  = (sub_row == '0) && (sub_col == '0);

  assign status.emit     = last_sub_col && last_sub_row;
  assign status.out_busy = dst_valid && !dst_ready;

  // read issued on capture, data used in the step cycle; counters are
  // still those of the current pixel then, so the same address is written
  abd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk     (clk),
    .wr_en   (cmd.step),
    .wr_addr (out_col),
    .wr_data (sums_next),
    .rd_en   (cmd.capture),
    .rd_addr (out_col),
    .rd_data (rd_data)
  );

  always_comb begin
    abd_sums_t old_sums;
    old_sums = abd_sums_t'(rd_data);
    for (int k = 0; k < NUM_CH; k++) begin
      if (block_start) begin
        sums_next[k] = SUM_W'(pixel[PIX_W-1-CH_W*k -: CH_W]);
      end else begin
        sums_next[k] = old_sums[k] + SUM_W'(pixel[PIX_W-1-CH_W*k -: CH_W]);
      end
    end
  end

  always_comb begin
    logic [QUOT_W-1:0] q;
    for (int k = 0; k < NUM_CH; k++) begin
      q = prod[k][PROD_W-1:RECIP_K];
      if (q > QUOT_W'(8'hff)) begin
        mean_pixel[PIX_W-1-CH_W*k -: CH_W] = 8'hff;
      end else begin
        mean_pixel[PIX_W-1-CH_W*k -: CH_W] = q[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pixel <= source_pixel;
    end
    if (cmd.step) begin
      sums       <= sums_next;
      line_flag  <= last_col;
      frame_flag <= last_col && last_row;
    end
    if (cmd.mul) begin
      for (int k = 0; k < NUM_CH; k++) begin
        prod[k] <= PROD_W'(sums[k]) * PROD_W'(abd_recip(cfg.scale));
      end
    end
    if (cmd.load) begin
      averaged_pixel <= mean_pixel;
      line_end       <= line_flag;
      frame_end      <= frame_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_col   <= '0;
      sub_row   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      dst_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (!last_sub_col) begin
          sub_col <= sub_col + 1'b1;
        end else begin
          sub_col <= '0;
          if (!last_col) begin
            out_col <= out_col + 1'b1;
          end else begin
            out_col <= '0;
            if (!last_sub_row) begin
              sub_row <= sub_row + 1'b1;
            end else begin
              sub_row <= '0;
              out_row <= last_row ? '0 : out_row + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/abd_controller.sv
// ----------------------------------------------------------------------------
// abd_controller
// Sequencer for capture, sum update, multiply and output load.
// ----------------------------------------------------------------------------
module abd_controller
  import abd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  abd_status_t status,
  output abd_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } abd_state_t;

  abd_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    src_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        src_ready = 1'b1;
        if (src_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.step   = 1'b1;
        state_next = status.emit ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the previous result beat to leave
        if (!status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/abd_checker.sv
// ----------------------------------------------------------------------------
// abd_checker
// Port-level checks of the box downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "argb_box_downsampler_core_macros.svh"

module abd_checker (
  input logic        clk,
  input logic        rst,
  input logic        src_valid,
  input logic        src_ready,
  input logic        dst_valid,
  input logic        dst_ready,
  input logic [31:0] averaged_pixel,
  input logic        line_end,
  input logic        frame_end
);

  // a stalled result beat holds
  `ABD_ASSERT(a_dst_hold, dst_valid && !dst_ready |=> dst_valid && $stable(averaged_pixel) && $stable(line_end) && $stable(frame_end), "stalled result beat changed")

  // the frame ends only on the end of a row
  `ABD_ASSERT(a_frame_on_line, dst_valid && frame_end |-> line_end, "frame_end without line_end")

  // one pixel in flight: no new beat right after one is taken
  `ABD_ASSERT(a_one_in_flight, src_valid && src_ready |=> !src_ready, "source beat taken back to back")

  // nothing leaves right after reset
  `ABD_ASSERT_ALWAYS(a_reset_empty, rst |=> !dst_valid, "result valid after reset")

endmodule

bind argb_box_downsampler_core abd_checker u_abd_checker (.*);
